@@ rtl/core/masked_flow_counter_top_n_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the flow counter
// Shared implication forms used by the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MASKED_FLOW_COUNTER_TOP_N_DEFINES_SVH
`define MASKED_FLOW_COUNTER_TOP_N_DEFINES_SVH

// same-cycle implication
`define MFC_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("check failed");

// next-cycle implication
`define MFC_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("check failed");

`endif

@@ rtl/core/mfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Flow counter package
// Widths, family codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package mfc_pkg;
	localparam int FlowEntriesDef = 1024;
	localparam logic [1:0] FAM_UNSPEC = 2'd0;
	localparam logic [1:0] FAM_IPV4   = 2'd1;
	localparam logic [1:0] FAM_IPV6   = 2'd2;
	localparam logic [1:0] FAM_LINK   = 2'd3;

	localparam logic [2:0] REG_USE_SRC_ADDR = 3'd0;
	localparam logic [2:0] REG_USE_DST_ADDR = 3'd1;
	localparam logic [2:0] REG_USE_SRC_PORT = 3'd2;
	localparam logic [2:0] REG_USE_DST_PORT = 3'd3;
	localparam logic [2:0] REG_USE_PROTO    = 3'd4;
	localparam logic [2:0] REG_REPORT_ROWS  = 3'd5;

	typedef struct packed {
		logic [1:0]  fam;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [15:0] port;
	} side_t;

	typedef struct packed {
		logic [1:0]  sfam;
		logic [1:0]  dfam;
		logic [63:0] shi;
		logic [63:0] slo;
		logic [15:0] sport;
		logic [63:0] dhi;
		logic [63:0] dlo;
		logic [15:0] dport;
		logic [7:0]  proto;
	} key_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SRCH_RD, ST_SRCH_CMP, ST_UPD_RD, ST_UPD_WR,
		ST_TOT, ST_SCAN_RD, ST_SCAN_CMP, ST_EMIT_RD, ST_EMIT, ST_CLEAR
	} state_t;

	function automatic side_t shape_side(input logic [1:0] fam, input logic [63:0] hi,
		input logic [63:0] lo, input logic [15:0] port, input logic keep_a,
		input logic keep_p);
		side_t s;
		s.fam = fam;
		s.hi = hi;
		s.lo = lo;
		s.port = port;
		case (fam)
			FAM_IPV4: begin
				s.hi = '0;
				s.lo = {32'd0, lo[31:0]};
			end
			FAM_LINK: begin
				s.hi = '0;
				s.lo = {16'd0, lo[47:0]};
				s.port = '0;
			end
			FAM_UNSPEC: begin
				s.hi = '0;
				s.lo = '0;
				s.port = '0;
			end
			default: ;
		endcase
		if (fam == FAM_IPV4 || fam == FAM_IPV6) begin
			if (!keep_a) begin
				s.hi = '0;
				s.lo = '0;
			end
			if (!keep_p)
				s.port = '0;
		end
		return s;
	endfunction

	function automatic logic side_match(input side_t s, input logic [1:0] fam,
		input logic [63:0] hi, input logic [63:0] lo, input logic [15:0] port);
		if (s.fam != fam)
			return 1'b0;
		if (fam == FAM_UNSPEC)
			return 1'b1;
		return (s.hi == hi) && (s.lo == lo) && (s.port == port);
	endfunction
endpackage

@@ rtl/core/masked_flow_counter_top_n.sv @@
// ----------------------------------------------------------------------------
// Masked flow counter with top-N report
// Masks packet keys, counts flows in a table, reports a total and ranked flows.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  in       | in_valid, in_stall, fields       | into block
//  out      | out_valid, out_stall, fields     | out of block
//  cfg      | cfg_we, cfg_index, cfg_data      | into block
//
// A packet word is handled by a linear search over the entries in use (one
// table read port), then an update. A report emits the total, then scans the
// table once per ranked row, and holds while the output is stalled. No clearing
// pass: the fill count alone marks live entries. out_stall holds the result
// register; no new word is taken until the current one finishes.
// ----------------------------------------------------------------------------
module masked_flow_counter_top_n import mfc_pkg::*; #(
	parameter int FLOW_ENTRIES = FlowEntriesDef,
	localparam int AW = $clog2(FLOW_ENTRIES)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [1:0]  src_family,
	input  logic [63:0] src_addr_hi,
	input  logic [63:0] src_addr_lo,
	input  logic [15:0] src_port,
	input  logic [1:0]  dst_family,
	input  logic [63:0] dst_addr_hi,
	input  logic [63:0] dst_addr_lo,
	input  logic [15:0] dst_port,
	input  logic [7:0]  proto_num,
	input  logic [15:0] wire_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  families,
	output logic [63:0] out_src_hi,
	output logic [63:0] out_src_lo,
	output logic [15:0] out_src_port,
	output logic [63:0] out_dst_hi,
	output logic [63:0] out_dst_lo,
	output logic [15:0] out_dst_port,
	output logic [7:0]  out_proto,
	output logic [63:0] byte_count,
	output logic [63:0] packet_count,
	output logic        is_total,
	output logic        last
);
`include "masked_flow_counter_top_n_defines.svh"

	logic use_sa_q, use_da_q, use_sp_q, use_dp_q, use_pr_q;
	logic [5:0] rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_sa_q <= 1'b1;
			use_da_q <= 1'b1;
			use_sp_q <= 1'b1;
			use_dp_q <= 1'b1;
			use_pr_q <= 1'b1;
			rows_q <= 6'd20;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_USE_SRC_ADDR: use_sa_q <= cfg_data[0];
				REG_USE_DST_ADDR: use_da_q <= cfg_data[0];
				REG_USE_SRC_PORT: use_sp_q <= cfg_data[0];
				REG_USE_DST_PORT: use_dp_q <= cfg_data[0];
				REG_USE_PROTO:    use_pr_q <= cfg_data[0];
				REG_REPORT_ROWS:  rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic [AW:0]   used_q, idx_q, best_q, prev_q, emitted_q, rows_lim_q;
	logic          have_q;
	logic [63:0]   sum_b_q, sum_p_q, best_b_q, best_p_q, prev_b_q, prev_p_q;
	side_t         s_q, d_q;
	logic [7:0]    proto_q;
	logic [15:0]   len_q;
	logic          found_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	key_t          wkey, rkey;
	logic [63:0]   wbytes, wpkts, rbytes, rpkts;

	mfc_table #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_table (
		.clk, .we, .waddr, .wkey, .wbytes, .wpkts, .raddr, .rkey, .rbytes, .rpkts
	);

	logic in_acc;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;

	logic hit;
	always_comb begin
		hit = (rkey.proto == proto_q);
		if (use_sa_q && !side_match(s_q, rkey.sfam, rkey.shi, rkey.slo, rkey.sport))
			hit = 1'b0;
		if (use_da_q && !side_match(d_q, rkey.dfam, rkey.dhi, rkey.dlo, rkey.dport))
			hit = 1'b0;
	end

	// rank compare: a before b
	logic cand_ok, cand_better;
	always_comb begin
		if (prev_b_q != rbytes)
			cand_ok = prev_b_q > rbytes;
		else if (prev_p_q != rpkts)
			cand_ok = prev_p_q > rpkts;
		else
			cand_ok = prev_q < idx_q;
		if (emitted_q == '0)
			cand_ok = 1'b1;
		if (rbytes != best_b_q)
			cand_better = rbytes > best_b_q;
		else if (rpkts != best_p_q)
			cand_better = rpkts > best_p_q;
		else
			cand_better = idx_q < best_q;
		if (!have_q)
			cand_better = 1'b1;
	end

	logic out_free;
	assign out_free = !out_valid || !out_stall;

	logic out_load;
	assign out_load = (state_q == ST_TOT || state_q == ST_EMIT) && out_free;

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wkey = {s_q.fam, d_q.fam, s_q.hi, s_q.lo, s_q.port, d_q.hi, d_q.lo,
			d_q.port, proto_q};
		wbytes = {48'd0, len_q};
		wpkts = 64'd1;
		raddr = idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: if (in_acc) state_d = mode ? ST_TOT : ST_SRCH_RD;
			ST_SRCH_RD: state_d = (idx_q < used_q) ? ST_SRCH_CMP : ST_UPD_WR;
			ST_SRCH_CMP: state_d = hit ? ST_UPD_RD : ST_SRCH_RD;
			ST_UPD_RD: state_d = ST_UPD_WR;
			ST_UPD_WR: begin
				if (found_q) begin
					we = 1'b1;
					wkey = rkey;
					wbytes = rbytes + {48'd0, len_q};
					wpkts = rpkts + 64'd1;
				end else if (used_q < (AW+1)'(FLOW_ENTRIES)) begin
					we = 1'b1;
					waddr = used_q[AW-1:0];
				end
				state_d = ST_IDLE;
			end
			ST_TOT: if (out_free)
				state_d = (rows_lim_q == '0) ? ST_CLEAR : ST_SCAN_RD;
			ST_SCAN_RD: state_d = (idx_q < used_q) ? ST_SCAN_CMP : ST_EMIT_RD;
			ST_SCAN_CMP: state_d = ST_SCAN_RD;
			ST_EMIT_RD: begin
				raddr = best_q[AW-1:0];
				state_d = have_q ? ST_EMIT : ST_CLEAR;
			end
			ST_EMIT: begin
				raddr = best_q[AW-1:0];
				if (out_free)
					state_d = (emitted_q + 1'b1 >= rows_lim_q) ? ST_CLEAR : ST_SCAN_RD;
			end
			ST_CLEAR: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			sum_b_q <= '0;
			sum_p_q <= '0;
			out_valid <= 1'b0;
			idx_q <= '0;
			have_q <= 1'b0;
			emitted_q <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_acc) begin
					idx_q <= '0;
					found_q <= 1'b0;
					have_q <= 1'b0;
					emitted_q <= '0;
				end
				ST_SRCH_RD: ;
				ST_SRCH_CMP: if (hit) found_q <= 1'b1;
					else idx_q <= idx_q + 1'b1;
				ST_UPD_WR: begin
					if (!found_q && used_q < (AW+1)'(FLOW_ENTRIES))
						used_q <= used_q + 1'b1;
					sum_b_q <= sum_b_q + {48'd0, len_q};
					sum_p_q <= sum_p_q + 64'd1;
				end
				ST_TOT: if (out_free) begin
					idx_q <= '0;
				end
				ST_SCAN_CMP: begin
					if (cand_ok && cand_better) begin
						have_q <= 1'b1;
						best_q <= idx_q;
						best_b_q <= rbytes;
						best_p_q <= rpkts;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_EMIT: if (out_free) begin
					emitted_q <= emitted_q + 1'b1;
					have_q <= 1'b0;
					idx_q <= '0;
				end
				ST_CLEAR: begin
					used_q <= '0;
					sum_b_q <= '0;
					sum_p_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_q <= shape_side(src_family, src_addr_hi, src_addr_lo, src_port,
				use_sa_q, use_sp_q);
			d_q <= shape_side(dst_family, dst_addr_hi, dst_addr_lo, dst_port,
				use_da_q, use_dp_q);
			proto_q <= use_pr_q ? proto_num : 8'd0;
			len_q <= wire_length;
			rows_lim_q <= ((AW+1)'(rows_q) > used_q) ? used_q : (AW+1)'(rows_q);
		end
		if (state_q == ST_EMIT && out_free) begin
			prev_q <= best_q;
			prev_b_q <= best_b_q;
			prev_p_q <= best_p_q;
		end
		if (state_q == ST_TOT && out_free) begin
			families <= '0;
			out_src_hi <= '0;
			out_src_lo <= '0;
			out_src_port <= '0;
			out_dst_hi <= '0;
			out_dst_lo <= '0;
			out_dst_port <= '0;
			out_proto <= '0;
			byte_count <= sum_b_q;
			packet_count <= sum_p_q;
			is_total <= 1'b1;
			last <= (rows_lim_q == '0);
		end
		if (state_q == ST_EMIT && out_free) begin
			families <= {rkey.sfam, rkey.dfam};
			out_src_hi <= rkey.shi;
			out_src_lo <= rkey.slo;
			out_src_port <= rkey.sport;
			out_dst_hi <= rkey.dhi;
			out_dst_lo <= rkey.dlo;
			out_dst_port <= rkey.dport;
			out_proto <= rkey.proto;
			byte_count <= rbytes;
			packet_count <= rpkts;
			is_total <= 1'b0;
			last <= (emitted_q + 1'b1 >= rows_lim_q);
		end
	end

	`MFC_ASSERT_IMP(a_used_bound, 1'b1, used_q <= (AW+1)'(FLOW_ENTRIES))
	`MFC_ASSERT_NXT(a_clear_empties, state_q == ST_CLEAR, used_q == '0)
	`MFC_ASSERT_IMP(a_stall_busy, out_valid, state_q != ST_IDLE || !in_stall)
endmodule

@@ rtl/core/mfc_table.sv @@
// ----------------------------------------------------------------------------
// Flow table storage
// Key and counter memories, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mfc_table import mfc_pkg::*; #(
	parameter int FLOW_ENTRIES = FlowEntriesDef,
	localparam int AW = $clog2(FLOW_ENTRIES)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  key_t          wkey,
	input  logic [63:0]   wbytes,
	input  logic [63:0]   wpkts,
	input  logic [AW-1:0] raddr,
	output key_t          rkey,
	output logic [63:0]   rbytes,
	output logic [63:0]   rpkts
);
	key_t        key_mem [FLOW_ENTRIES];
	logic [63:0] byte_mem [FLOW_ENTRIES];
	logic [63:0] pkt_mem [FLOW_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			byte_mem[waddr] <= wbytes;
			pkt_mem[waddr] <= wpkts;
		end
		rkey <= key_mem[raddr];
		rbytes <= byte_mem[raddr];
		rpkts <= pkt_mem[raddr];
	end
endmodule
